// ===== src/aae_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive arithmetic encoder package
// Shared types, constants and controller states for the encoder block.
// ----------------------------------------------------------------------------
package aae_pkg;

    localparam int unsigned MODELS    = 4;
    localparam int unsigned MODEL_W   = 2;
    localparam int unsigned IDX_W     = 9;
    localparam int unsigned ADDR_W    = MODEL_W + IDX_W;
    localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
    localparam int unsigned FREQ_W    = 14;
    localparam int unsigned CODE_W    = 16;
    localparam int unsigned RANGE_W   = CODE_W + 1;
    localparam int unsigned PROD_W    = RANGE_W + FREQ_W;
    localparam int unsigned CNT_W     = 6;

    localparam logic [CODE_W-1:0] HALF_V  = 16'h8000;
    localparam logic [CODE_W-1:0] QTR_V   = 16'h4000;
    localparam logic [CODE_W-1:0] TQTR_V  = 16'hC000;
    localparam logic [CODE_W-1:0] FOLLOW_MAX = 16'hFFFF;
    localparam logic [FREQ_W-1:0] MAX_FREQ = 14'h3FFF;
    localparam logic [IDX_W-1:0]  MAX_CHARS = 9'd256;
    localparam logic [IDX_W-1:0]  LAST_SLOT = 9'd257;
    localparam logic [CNT_W-1:0]  MAX_RESULTS = 6'd33;
    localparam logic [CNT_W-1:0]  RENORM_LIMIT = 6'd34;

    localparam logic [1:0] KIND_ENCODE = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] model_sel;
        logic [7:0] sym_in;
    } in_item_t;

    typedef struct packed {
        logic        lead_bit;
        logic [15:0] follow_run;
        logic        last_out;
    } out_item_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CLEAR, ST_INIT, ST_DISP,
        ST_E_S2R, ST_E_RANK, ST_E_ESC,
        ST_N_RDHI, ST_N_RDLO, ST_N_RDTOT, ST_N_CAPT,
        ST_N_MULHI, ST_N_DSHI, ST_N_WHI, ST_N_MULLO, ST_N_DSLO, ST_N_WLO,
        ST_N_APPLY, ST_N_RENORM, ST_N_DONE,
        ST_F_EMIT, ST_X_FLUSH,
        ST_U_RDC0, ST_U_C0, ST_U_SRD, ST_U_SWR, ST_U_SEND,
        ST_U_CIRD, ST_U_CIWR, ST_U_SYM, ST_U_SYMD, ST_U_FS,
        ST_U_SCRD, ST_U_SCMP, ST_U_SWCHK, ST_U_RB, ST_U_RA, ST_U_W2,
        ST_U_FRD, ST_U_FWR, ST_U_END
    } state_t;

    typedef struct packed {
        state_t op;
        logic   accept;
        logic   pick_clear;
    } cmd_t;

    typedef struct packed {
        logic       any_dirty;
        logic       item_ok;
        logic [1:0] kind;
        logic       rank_zero;
        logic       c0_big;
        logic       div_busy;
        logic       tot_zero;
        logic       rn_stop;
        logic       emit_stall;
        logic       i_zero;
        logic       ns_full;
        logic       sc_eq;
        logic       swap_need;
        logic       clr_last;
        logic       out_free;
        logic       hold_valid;
        logic       inc_final;
        logic       uni;
    } status_t;

    function automatic logic [ADDR_W-1:0] mem_idx(logic [MODEL_W-1:0] m,
                                                   logic [IDX_W-1:0] x);
        return {m, x};
    endfunction

endpackage

// ===== src/aae_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Divides the registered product by the model total, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module aae_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [aae_pkg::PROD_W-1:0]        dividend,
    input  logic [aae_pkg::FREQ_W-1:0]        divisor,
    output logic                              busy,
    output logic [aae_pkg::CODE_W-1:0]        quotient
);

    logic [aae_pkg::PROD_W-1:0] dvd_reg, dvd_next;
    logic [aae_pkg::FREQ_W-1:0] rem_reg, rem_next;
    logic [aae_pkg::CODE_W-1:0] quo_reg, quo_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [aae_pkg::FREQ_W:0]   trial;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, dvd_reg[aae_pkg::PROD_W-1]};
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 5'(aae_pkg::PROD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Only the low quotient bits are kept; the code interval wraps anyway.
            if (trial >= {1'b0, divisor}) begin
                rem_next = aae_pkg::FREQ_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[aae_pkg::CODE_W-2:0], 1'b1};
            end else begin
                rem_next = trial[aae_pkg::FREQ_W-1:0];
                quo_next = {quo_reg[aae_pkg::CODE_W-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[aae_pkg::PROD_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/aae_ctrl.sv =====
// ----------------------------------------------------------------------------
// Encoder controller
// Sequences clearing, encoding, model update and result flushing.
// ----------------------------------------------------------------------------
module aae_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aae_pkg::status_t  sts,
    output aae_pkg::cmd_t     cmd
);

    aae_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aae_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.op         = state_reg;
        cmd.accept     = 1'b0;
        cmd.pick_clear = 1'b0;
        s_ready        = 1'b0;
        unique case (state_reg)
            aae_pkg::ST_IDLE: begin
                if (sts.any_dirty) begin
                    cmd.pick_clear = 1'b1;
                    state_next     = aae_pkg::ST_CLEAR;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.accept = 1'b1;
                        state_next = aae_pkg::ST_DISP;
                    end
                end
            end
            aae_pkg::ST_CLEAR: if (sts.clr_last) state_next = aae_pkg::ST_INIT;
            aae_pkg::ST_INIT:  state_next = aae_pkg::ST_IDLE;
            aae_pkg::ST_DISP: begin
                if (!sts.item_ok) begin
                    state_next = aae_pkg::ST_IDLE;
                end else if (sts.kind == aae_pkg::KIND_FINISH) begin
                    state_next = aae_pkg::ST_F_EMIT;
                end else if (sts.kind == aae_pkg::KIND_ENCODE) begin
                    state_next = aae_pkg::ST_E_S2R;
                end else begin
                    state_next = aae_pkg::ST_U_RDC0;
                end
            end
            aae_pkg::ST_E_S2R:  state_next = aae_pkg::ST_E_RANK;
            aae_pkg::ST_E_RANK: begin
                state_next = sts.rank_zero ? aae_pkg::ST_E_ESC : aae_pkg::ST_N_RDHI;
            end
            aae_pkg::ST_E_ESC:   state_next = aae_pkg::ST_N_RDHI;
            aae_pkg::ST_N_RDHI:  state_next = aae_pkg::ST_N_RDLO;
            aae_pkg::ST_N_RDLO:  state_next = aae_pkg::ST_N_RDTOT;
            aae_pkg::ST_N_RDTOT: state_next = aae_pkg::ST_N_CAPT;
            aae_pkg::ST_N_CAPT:  state_next = aae_pkg::ST_N_MULHI;
            aae_pkg::ST_N_MULHI: begin
                state_next = sts.tot_zero ? aae_pkg::ST_N_DONE : aae_pkg::ST_N_DSHI;
            end
            aae_pkg::ST_N_DSHI:  state_next = aae_pkg::ST_N_WHI;
            aae_pkg::ST_N_WHI:   if (!sts.div_busy) state_next = aae_pkg::ST_N_MULLO;
            aae_pkg::ST_N_MULLO: state_next = aae_pkg::ST_N_DSLO;
            aae_pkg::ST_N_DSLO:  state_next = aae_pkg::ST_N_WLO;
            aae_pkg::ST_N_WLO:   if (!sts.div_busy) state_next = aae_pkg::ST_N_APPLY;
            aae_pkg::ST_N_APPLY: state_next = aae_pkg::ST_N_RENORM;
            aae_pkg::ST_N_RENORM: if (sts.rn_stop) state_next = aae_pkg::ST_N_DONE;
            aae_pkg::ST_N_DONE: begin
                state_next = sts.uni ? aae_pkg::ST_N_MULHI : aae_pkg::ST_X_FLUSH;
            end
            aae_pkg::ST_F_EMIT: if (!sts.emit_stall) state_next = aae_pkg::ST_X_FLUSH;
            aae_pkg::ST_X_FLUSH: begin
                if (!sts.hold_valid || sts.out_free) state_next = aae_pkg::ST_IDLE;
            end
            aae_pkg::ST_U_RDC0: state_next = aae_pkg::ST_U_C0;
            aae_pkg::ST_U_C0: begin
                state_next = sts.c0_big ? aae_pkg::ST_U_SRD : aae_pkg::ST_U_SYM;
            end
            aae_pkg::ST_U_SRD: begin
                state_next = sts.i_zero ? aae_pkg::ST_U_SEND : aae_pkg::ST_U_SWR;
            end
            aae_pkg::ST_U_SWR:  state_next = aae_pkg::ST_U_SRD;
            aae_pkg::ST_U_SEND: state_next = aae_pkg::ST_U_CIRD;
            aae_pkg::ST_U_CIRD: begin
                if (!sts.i_zero) begin
                    state_next = aae_pkg::ST_U_CIWR;
                end else begin
                    state_next = sts.inc_final ? aae_pkg::ST_U_END : aae_pkg::ST_U_SYM;
                end
            end
            aae_pkg::ST_U_CIWR: state_next = aae_pkg::ST_U_CIRD;
            aae_pkg::ST_U_SYM:  state_next = aae_pkg::ST_U_SYMD;
            aae_pkg::ST_U_SYMD: begin
                if (!sts.rank_zero) begin
                    state_next = aae_pkg::ST_U_FS;
                end else begin
                    state_next = sts.ns_full ? aae_pkg::ST_U_END : aae_pkg::ST_U_FRD;
                end
            end
            aae_pkg::ST_U_FS: state_next = aae_pkg::ST_U_SCRD;
            aae_pkg::ST_U_SCRD: begin
                state_next = sts.i_zero ? aae_pkg::ST_U_SWCHK : aae_pkg::ST_U_SCMP;
            end
            aae_pkg::ST_U_SCMP: begin
                state_next = sts.sc_eq ? aae_pkg::ST_U_SCRD : aae_pkg::ST_U_SWCHK;
            end
            aae_pkg::ST_U_SWCHK: begin
                state_next = sts.swap_need ? aae_pkg::ST_U_RB : aae_pkg::ST_U_FRD;
            end
            aae_pkg::ST_U_RB:  state_next = aae_pkg::ST_U_RA;
            aae_pkg::ST_U_RA:  state_next = aae_pkg::ST_U_W2;
            aae_pkg::ST_U_W2:  state_next = aae_pkg::ST_U_FRD;
            aae_pkg::ST_U_FRD: state_next = aae_pkg::ST_U_FWR;
            aae_pkg::ST_U_FWR: state_next = aae_pkg::ST_U_CIRD;
            aae_pkg::ST_U_END: state_next = aae_pkg::ST_X_FLUSH;
            default:           state_next = aae_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/aae_dp.sv =====
// ----------------------------------------------------------------------------
// Encoder datapath
// Model tables, code interval, follow counter and the result registers.
// ----------------------------------------------------------------------------
module aae_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  aae_pkg::cmd_t       cmd,
    output aae_pkg::status_t    sts,
    input  aae_pkg::in_item_t   s_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_wdata,
    output logic                m_valid,
    input  logic                m_ready,
    output aae_pkg::out_item_t  m_data
);

    localparam int unsigned AW = aae_pkg::ADDR_W;
    localparam int unsigned IW = aae_pkg::IDX_W;
    localparam int unsigned FW = aae_pkg::FREQ_W;
    localparam int unsigned CW = aae_pkg::CODE_W;

    // Model tables.
    logic [FW-1:0] f_mem   [aae_pkg::MEM_DEPTH];
    logic [FW-1:0] c_mem   [aae_pkg::MEM_DEPTH];
    logic [IW-1:0] r2s_mem [aae_pkg::MEM_DEPTH];
    logic [IW-1:0] s2r_mem [aae_pkg::MEM_DEPTH];

    logic          f_we, c_we, r2s_we, s2r_we;
    logic [AW-1:0] f_wa, c_wa, r2s_wa, s2r_wa;
    logic [AW-1:0] f_ra, c_ra, r2s_ra, s2r_ra;
    logic [FW-1:0] f_wd, c_wd;
    logic [IW-1:0] r2s_wd, s2r_wd;
    logic [FW-1:0] f_rd_reg, c_rd_reg;
    logic [IW-1:0] r2s_rd_reg, s2r_rd_reg;

    // Configuration and per-model state.
    logic [IW-1:0] asize_reg [aae_pkg::MODELS];
    logic [IW-1:0] used_reg  [aae_pkg::MODELS];
    logic [aae_pkg::MODELS-1:0] dirty_reg;
    logic [1:0]    clr_m_reg;
    logic [IW-1:0] clr_reg;

    // Item and working registers.
    aae_pkg::in_item_t item_reg;
    logic [CW-1:0] low_reg, high_reg, follow_reg;
    logic [aae_pkg::CNT_W-1:0] ocnt_reg, guard_reg;
    logic [IW-1:0] r_reg, ns_reg, i_reg, sym_reg, a_reg, b_reg;
    logic [FW-1:0] hic_reg, loc_reg, tot_reg, fs_reg, acc_reg;
    logic [aae_pkg::RANGE_W-1:0] range_reg;
    logic [aae_pkg::PROD_W-1:0]  prod_reg;
    logic [CW-1:0] qhi_reg;
    logic          uni_reg, inc_final_reg;

    // Result staging: the newest result is held back until the next one, or
    // the end of the item, shows whether it is the final beat.
    logic          hold_v_reg, hold_bit_reg;
    logic [CW-1:0] hold_run_reg;
    logic          out_v_reg;
    aae_pkg::out_item_t out_reg;

    logic [1:0]    m_sel;
    logic [IW-1:0] n, n_clr, ch, ns_p;
    logic [aae_pkg::RANGE_W-1:0] range_w;
    logic          div_start, div_busy;
    logic [CW-1:0] div_q;
    logic [CW-1:0] follow_inc;
    logic          c1, c2, c3, rn_stop, stall, emit_req, do_emit, flush_move;
    logic          emit_bit;
    logic [CW-1:0] emit_run;
    logic [FW-1:0] fh;
    logic [1:0]    pick;
    logic [CW-1:0] lm, hm;

    assign m_sel = item_reg.model_sel;
    assign n     = asize_reg[m_sel];
    assign n_clr = asize_reg[clr_m_reg];
    assign ch    = {1'b0, item_reg.sym_in};
    assign ns_p  = (ns_reg + 9'd1 < aae_pkg::LAST_SLOT + 9'd1) ? ns_reg + 9'd1 : ns_reg;
    assign fh    = f_rd_reg >> 1;
    assign range_w = {1'b0, high_reg} - {1'b0, low_reg} + 17'd1;
    assign follow_inc = (follow_reg == aae_pkg::FOLLOW_MAX) ? follow_reg
                                                            : follow_reg + 16'd1;

    always_comb begin
        pick = '0;
        for (int k = aae_pkg::MODELS - 1; k >= 0; k--) begin
            if (dirty_reg[k]) pick = 2'(k);
        end
    end

    // Renormalisation decisions.
    assign c1 = high_reg < aae_pkg::HALF_V;
    assign c2 = low_reg >= aae_pkg::HALF_V;
    assign c3 = (low_reg >= aae_pkg::QTR_V) && (high_reg < aae_pkg::TQTR_V);
    assign rn_stop = (guard_reg == aae_pkg::RENORM_LIMIT) || !(c1 || c2 || c3);
    assign stall = hold_v_reg && out_v_reg && !m_ready;

    always_comb begin
        emit_req = 1'b0;
        emit_bit = 1'b0;
        emit_run = follow_reg;
        if (cmd.op == aae_pkg::ST_N_RENORM && !rn_stop && (c1 || c2)) begin
            emit_req = 1'b1;
            emit_bit = !c1;
        end else if (cmd.op == aae_pkg::ST_F_EMIT) begin
            emit_req = 1'b1;
            emit_bit = !(low_reg < aae_pkg::QTR_V);
            emit_run = follow_inc;
        end
    end
    assign do_emit    = emit_req && !stall;
    assign flush_move = (cmd.op == aae_pkg::ST_X_FLUSH) && hold_v_reg
                        && (!out_v_reg || m_ready);

    always_comb begin
        lm = low_reg;
        hm = high_reg;
        if (c1) begin
            lm = low_reg;
        end else if (c2) begin
            lm = low_reg - aae_pkg::HALF_V;
            hm = high_reg - aae_pkg::HALF_V;
        end else begin
            lm = low_reg - aae_pkg::QTR_V;
            hm = high_reg - aae_pkg::QTR_V;
        end
    end

    assign div_start = (cmd.op == aae_pkg::ST_N_DSHI) || (cmd.op == aae_pkg::ST_N_DSLO);

    aae_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (tot_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Table port control.
    always_comb begin
        f_we = 1'b0;   f_wa = '0;   f_wd = '0;
        c_we = 1'b0;   c_wa = '0;   c_wd = '0;
        r2s_we = 1'b0; r2s_wa = '0; r2s_wd = '0;
        s2r_we = 1'b0; s2r_wa = '0; s2r_wd = '0;
        f_ra   = aae_pkg::mem_idx(m_sel, i_reg);
        c_ra   = aae_pkg::mem_idx(m_sel, i_reg);
        r2s_ra = aae_pkg::mem_idx(m_sel, i_reg);
        s2r_ra = aae_pkg::mem_idx(m_sel, ch);
        unique case (cmd.op)
            aae_pkg::ST_CLEAR: begin
                f_we = 1'b1;   f_wa = aae_pkg::mem_idx(clr_m_reg, clr_reg);
                c_we = 1'b1;   c_wa = aae_pkg::mem_idx(clr_m_reg, clr_reg);
                r2s_we = 1'b1; r2s_wa = aae_pkg::mem_idx(clr_m_reg, clr_reg);
                s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(clr_m_reg, clr_reg);
            end
            aae_pkg::ST_INIT: begin
                s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(clr_m_reg, n_clr); s2r_wd = 9'd1;
                r2s_we = 1'b1; r2s_wa = aae_pkg::mem_idx(clr_m_reg, 9'd1);  r2s_wd = n_clr;
                f_we = 1'b1;   f_wa = aae_pkg::mem_idx(clr_m_reg, 9'd1);    f_wd = 14'd1;
                c_we = 1'b1;   c_wa = aae_pkg::mem_idx(clr_m_reg, 9'd0);    c_wd = 14'd1;
            end
            aae_pkg::ST_E_RANK: s2r_ra = aae_pkg::mem_idx(m_sel, n);
            aae_pkg::ST_N_RDHI: c_ra = aae_pkg::mem_idx(m_sel, r_reg - 9'd1);
            aae_pkg::ST_N_RDLO: c_ra = aae_pkg::mem_idx(m_sel, r_reg);
            aae_pkg::ST_N_RDTOT, aae_pkg::ST_U_RDC0: c_ra = aae_pkg::mem_idx(m_sel, 9'd0);
            aae_pkg::ST_U_SWR: begin
                f_we = 1'b1; f_wa = aae_pkg::mem_idx(m_sel, i_reg); f_wd = fh;
                c_we = 1'b1; c_wa = aae_pkg::mem_idx(m_sel, i_reg); c_wd = acc_reg;
                if (fh == '0 && r2s_rd_reg <= aae_pkg::MAX_CHARS) begin
                    s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(m_sel, r2s_rd_reg);
                end
            end
            aae_pkg::ST_U_SEND: begin
                c_we = 1'b1;   c_wa = aae_pkg::mem_idx(m_sel, 9'd0); c_wd = acc_reg;
                s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(m_sel, n);  s2r_wd = ns_p;
                r2s_we = 1'b1; r2s_wa = aae_pkg::mem_idx(m_sel, ns_p); r2s_wd = n;
                f_we = 1'b1;   f_wa = aae_pkg::mem_idx(m_sel, ns_p); f_wd = 14'd1;
            end
            aae_pkg::ST_U_CIRD: c_ra = aae_pkg::mem_idx(m_sel, i_reg - 9'd1);
            aae_pkg::ST_U_CIWR: begin
                c_we = 1'b1; c_wa = aae_pkg::mem_idx(m_sel, i_reg); c_wd = c_rd_reg + 14'd1;
            end
            aae_pkg::ST_U_SYMD: begin
                if (s2r_rd_reg == '0) begin
                    if (!(ns_reg + 9'd1 >= aae_pkg::LAST_SLOT + 9'd1)) begin
                        s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(m_sel, ch);
                        s2r_wd = ns_reg + 9'd1;
                        r2s_we = 1'b1; r2s_wa = aae_pkg::mem_idx(m_sel, ns_reg + 9'd1);
                        r2s_wd = ch;
                    end
                end else begin
                    f_ra = aae_pkg::mem_idx(m_sel, s2r_rd_reg);
                end
            end
            aae_pkg::ST_U_SCRD:  f_ra = aae_pkg::mem_idx(m_sel, i_reg - 9'd1);
            aae_pkg::ST_U_SWCHK: r2s_ra = aae_pkg::mem_idx(m_sel, sym_reg);
            aae_pkg::ST_U_RA: begin
                r2s_we = 1'b1; r2s_wa = aae_pkg::mem_idx(m_sel, i_reg); r2s_wd = b_reg;
                if (r2s_rd_reg <= aae_pkg::MAX_CHARS) begin
                    s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(m_sel, r2s_rd_reg);
                    s2r_wd = sym_reg;
                end
            end
            aae_pkg::ST_U_W2: begin
                r2s_we = 1'b1; r2s_wa = aae_pkg::mem_idx(m_sel, sym_reg); r2s_wd = a_reg;
                if (b_reg <= aae_pkg::MAX_CHARS) begin
                    s2r_we = 1'b1; s2r_wa = aae_pkg::mem_idx(m_sel, b_reg); s2r_wd = i_reg;
                end
            end
            aae_pkg::ST_U_FWR: begin
                f_we = 1'b1; f_wa = aae_pkg::mem_idx(m_sel, i_reg); f_wd = f_rd_reg + 14'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (f_we) f_mem[f_wa] <= f_wd;
        if (c_we) c_mem[c_wa] <= c_wd;
        if (r2s_we) r2s_mem[r2s_wa] <= r2s_wd;
        if (s2r_we) s2r_mem[s2r_wa] <= s2r_wd;
        f_rd_reg   <= f_mem[f_ra];
        c_rd_reg   <= c_mem[c_ra];
        r2s_rd_reg <= r2s_mem[r2s_ra];
        s2r_rd_reg <= s2r_mem[s2r_ra];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg  <= '1;
            low_reg    <= '0;
            high_reg   <= '1;
            follow_reg <= '0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            ocnt_reg   <= '0;
            for (int k = 0; k < aae_pkg::MODELS; k++) begin
                asize_reg[k] <= aae_pkg::MAX_CHARS;
            end
        end else begin
            if (cmd.pick_clear) dirty_reg[pick] <= 1'b0;
            if (cfg_we) begin
                dirty_reg[cfg_index] <= 1'b1;
                if (cfg_wdata == '0) begin
                    asize_reg[cfg_index] <= 9'd1;
                end else if (cfg_wdata > aae_pkg::MAX_CHARS) begin
                    asize_reg[cfg_index] <= aae_pkg::MAX_CHARS;
                end else begin
                    asize_reg[cfg_index] <= cfg_wdata;
                end
            end

            if (cmd.accept) ocnt_reg <= '0;

            if (cmd.op == aae_pkg::ST_N_APPLY) begin
                high_reg <= low_reg + qhi_reg - 16'd1;
                low_reg  <= low_reg + div_q;
            end
            if (cmd.op == aae_pkg::ST_N_RENORM && !rn_stop && ((c1 || c2) ? !stall : 1'b1)) begin
                low_reg  <= {lm[CW-2:0], 1'b0};
                high_reg <= {hm[CW-2:0], 1'b1};
                if (!c1 && !c2) follow_reg <= follow_inc;
            end

            if (do_emit) begin
                follow_reg <= '0;
                if (ocnt_reg < aae_pkg::MAX_RESULTS) begin
                    ocnt_reg   <= ocnt_reg + 6'd1;
                    hold_v_reg <= 1'b1;
                end
            end else if (flush_move) begin
                hold_v_reg <= 1'b0;
            end

            if ((do_emit && ocnt_reg < aae_pkg::MAX_RESULTS && hold_v_reg) || flush_move) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Result payloads.
    always_ff @(posedge aclk) begin
        if ((do_emit && ocnt_reg < aae_pkg::MAX_RESULTS && hold_v_reg) || flush_move) begin
            out_reg.lead_bit   <= hold_bit_reg;
            out_reg.follow_run <= hold_run_reg;
            out_reg.last_out   <= flush_move;
        end
        if (do_emit && ocnt_reg < aae_pkg::MAX_RESULTS) begin
            hold_bit_reg <= emit_bit;
            hold_run_reg <= emit_run;
        end
    end

    // Model bookkeeping and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uni_reg       <= 1'b0;
            inc_final_reg <= 1'b0;
            clr_m_reg     <= '0;
            clr_reg       <= '0;
        end else begin
            if (cmd.pick_clear) begin
                clr_m_reg <= pick;
                clr_reg   <= '0;
            end
            if (cmd.accept) uni_reg <= 1'b0;
            unique case (cmd.op)
                aae_pkg::ST_CLEAR: clr_reg <= clr_reg + 9'd1;
                aae_pkg::ST_E_ESC: uni_reg <= 1'b1;
                aae_pkg::ST_N_DONE: uni_reg <= 1'b0;
                aae_pkg::ST_U_SEND: inc_final_reg <= 1'b0;
                aae_pkg::ST_U_FWR: inc_final_reg <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) item_reg <= s_data;
        unique case (cmd.op)
            aae_pkg::ST_INIT: used_reg[clr_m_reg] <= 9'd1;
            aae_pkg::ST_E_RANK: r_reg <= s2r_rd_reg;
            aae_pkg::ST_E_ESC: r_reg <= (s2r_rd_reg == '0) ? 9'd1 : s2r_rd_reg;
            aae_pkg::ST_N_RDLO: hic_reg <= c_rd_reg;
            aae_pkg::ST_N_RDTOT: loc_reg <= c_rd_reg;
            aae_pkg::ST_N_CAPT: tot_reg <= c_rd_reg;
            aae_pkg::ST_N_MULHI: begin
                range_reg <= range_w;
                prod_reg  <= aae_pkg::PROD_W'(range_w) * aae_pkg::PROD_W'(hic_reg);
            end
            aae_pkg::ST_N_MULLO: begin
                qhi_reg  <= div_q;
                prod_reg <= aae_pkg::PROD_W'(range_reg) * aae_pkg::PROD_W'(loc_reg);
            end
            aae_pkg::ST_N_APPLY: guard_reg <= '0;
            aae_pkg::ST_N_RENORM: begin
                if (!rn_stop && ((c1 || c2) ? !stall : 1'b1)) guard_reg <= guard_reg + 6'd1;
            end
            aae_pkg::ST_N_DONE: begin
                // Escape has been coded; the symbol follows as one of n + 1 equal slots.
                hic_reg <= FW'(n + 9'd1 - ch);
                loc_reg <= FW'(n - ch);
                tot_reg <= FW'({1'b0, n} + 10'd1);
            end
            aae_pkg::ST_U_RDC0: ns_reg <= used_reg[m_sel];
            aae_pkg::ST_U_C0: begin
                i_reg   <= ns_reg;
                acc_reg <= '0;
            end
            aae_pkg::ST_U_SWR: begin
                if (fh == '0 && ns_reg != '0) ns_reg <= ns_reg - 9'd1;
                acc_reg <= acc_reg + fh;
                i_reg   <= i_reg - 9'd1;
            end
            aae_pkg::ST_U_SEND: begin
                ns_reg <= ns_p;
                i_reg  <= ns_p;
            end
            aae_pkg::ST_U_CIRD: if (i_reg != '0) i_reg <= i_reg - 9'd1;
            aae_pkg::ST_U_SYMD: begin
                sym_reg <= s2r_rd_reg;
                if (s2r_rd_reg != '0) begin
                    i_reg <= s2r_rd_reg;
                end else if (!(ns_reg + 9'd1 >= aae_pkg::LAST_SLOT + 9'd1)) begin
                    ns_reg <= ns_reg + 9'd1;
                    i_reg  <= ns_reg + 9'd1;
                end
            end
            aae_pkg::ST_U_FS: fs_reg <= f_rd_reg;
            aae_pkg::ST_U_SCMP: if (f_rd_reg == fs_reg) i_reg <= i_reg - 9'd1;
            aae_pkg::ST_U_RB: b_reg <= r2s_rd_reg;
            aae_pkg::ST_U_RA: a_reg <= r2s_rd_reg;
            aae_pkg::ST_U_END: used_reg[m_sel] <= ns_reg;
            default: begin
            end
        endcase
    end

    always_comb begin
        sts.any_dirty  = |dirty_reg;
        sts.item_ok    = (item_reg.kind == aae_pkg::KIND_FINISH)
                         || ((item_reg.kind == aae_pkg::KIND_ENCODE
                              || item_reg.kind == aae_pkg::KIND_UPDATE) && ch < n);
        sts.kind       = item_reg.kind;
        sts.rank_zero  = s2r_rd_reg == '0;
        sts.c0_big     = c_rd_reg >= aae_pkg::MAX_FREQ;
        sts.div_busy   = div_busy;
        sts.tot_zero   = tot_reg == '0;
        sts.rn_stop    = rn_stop;
        sts.emit_stall = stall;
        sts.i_zero     = i_reg == '0;
        sts.ns_full    = ns_reg + 9'd1 >= aae_pkg::LAST_SLOT + 9'd1;
        sts.sc_eq      = f_rd_reg == fs_reg;
        sts.swap_need  = i_reg < sym_reg;
        sts.clr_last   = clr_reg == aae_pkg::LAST_SLOT;
        sts.out_free   = !out_v_reg || m_ready;
        sts.hold_valid = hold_v_reg;
        sts.inc_final  = inc_final_reg;
        sts.uni        = uni_reg;
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/adaptive_arithmetic_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Adaptive arithmetic encoder
// Four adaptive frequency models with escape coding and a 16-bit code interval.
//
//   Channel  Ports                        Beat
//   input    s_valid s_ready s_data       kind, model_sel, sym_in
//   result   m_valid m_ready m_data       lead_bit, follow_run, last_out
//   config   cfg_we cfg_index cfg_wdata   alphabet size of one model
//
// One item at a time. An encode narrows the interval with two divisions and then
// renormalises in rounds; an unseen symbol narrows twice. An update visits the
// ranks one by one, and a rescale walks every used rank twice more. After reset,
// and after each alphabet size write, the model tables are cleared one model at
// a time (all four after reset) with s_ready low.
// A stalled result channel holds the item at its next result bit.
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aae_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aae_pkg::out_item_t  m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_wdata
);

    aae_pkg::cmd_t    cmd;
    aae_pkg::status_t sts;

    aae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aae_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sim/tb_adaptive_arithmetic_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Adaptive arithmetic encoder testbench
// Drives encode, update and finish beats into the encoder under random
// back-pressure, predicts every result beat with a local model of the four
// adaptive frequency models and compares them field by field.
// ----------------------------------------------------------------------------
module tb_adaptive_arithmetic_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NSLOT   = 258;
    localparam longint      TOP_C   = 64'hFFFF;
    localparam longint      HALF_C  = 64'h8000;
    localparam longint      QTR_C   = 64'h4000;
    localparam longint      TQTR_C  = 64'hC000;
    localparam int unsigned FREQ_LIM = 16383;
    localparam int unsigned RUN_SAT = 65535;
    localparam int          DRAIN   = 2000;
    localparam logic [1:0]  KIND_RESERVED = 2'd3;

    // Local copy of the coder: interval, follow count and the model tables.
    class encoder_scoreboard;
        longint      lo_q, hi_q;
        int unsigned follow_q;
        int unsigned freq [aae_pkg::MODELS][NSLOT];
        int unsigned cum  [aae_pkg::MODELS][NSLOT];
        int unsigned s2r  [aae_pkg::MODELS][NSLOT];
        int unsigned r2s  [aae_pkg::MODELS][NSLOT];
        int unsigned used [aae_pkg::MODELS];
        int unsigned asz  [aae_pkg::MODELS];
        aae_pkg::out_item_t pending_beats[$];
        int          n_emit;
        int          errors;

        function void reset_all();
            lo_q = 0;
            hi_q = TOP_C;
            follow_q = 0;
            for (int m = 0; m < aae_pkg::MODELS; m++) begin
                asz[m] = 256;
                clear_model(m);
            end
        endfunction

        function void clear_model(int m);
            for (int i = 0; i < NSLOT; i++) begin
                freq[m][i] = 0; cum[m][i] = 0; s2r[m][i] = 0; r2s[m][i] = 0;
            end
            s2r[m][asz[m]] = 1;
            r2s[m][1] = asz[m];
            freq[m][1] = 1;
            cum[m][0] = 1;
            used[m] = 1;
        endfunction

        function void set_size(int m, logic [8:0] v);
            if (v == 0) asz[m] = 1;
            else if (v > 256) asz[m] = 256;
            else asz[m] = int'(v);
            clear_model(m);
        endfunction

        function void emit_bit(bit b);
            aae_pkg::out_item_t o;
            if (n_emit < aae_pkg::MAX_RESULTS) begin
                o.lead_bit = b;
                o.follow_run = follow_q[15:0];
                o.last_out = 1'b0;
                pending_beats.push_back(o);
                n_emit++;
            end
            follow_q = 0;
        endfunction

        function void bump_follow();
            if (follow_q < RUN_SAT) follow_q++;
        endfunction

        function void narrow(longint hc, longint lc, longint total);
            longint rng;
            if (total == 0) return;
            rng = hi_q - lo_q + 1;
            hi_q = (lo_q + rng * hc / total - 1) & TOP_C;
            lo_q = (lo_q + rng * lc / total) & TOP_C;
            for (int g = 0; g < aae_pkg::RENORM_LIMIT; g++) begin
                if (hi_q < HALF_C) begin
                    emit_bit(1'b0);
                end else if (lo_q >= HALF_C) begin
                    emit_bit(1'b1);
                    lo_q -= HALF_C;
                    hi_q -= HALF_C;
                end else if (lo_q >= QTR_C && hi_q < TQTR_C) begin
                    lo_q -= QTR_C;
                    hi_q -= QTR_C;
                    bump_follow();
                end else begin
                    return;
                end
                lo_q = (lo_q << 1) & TOP_C;
                hi_q = ((hi_q << 1) | 1) & TOP_C;
            end
        endfunction

        function int unsigned clip_rank(int unsigned r);
            return (r >= NSLOT) ? NSLOT - 1 : r;
        endfunction

        function void encode_sym(int m, int unsigned ch);
            int unsigned n, r;
            n = asz[m];
            r = clip_rank(s2r[m][ch]);
            if (r != 0) begin
                narrow(cum[m][r-1], cum[m][r], cum[m][0]);
                return;
            end
            r = clip_rank(s2r[m][n]);
            if (r == 0) r = 1;
            narrow(cum[m][r-1], cum[m][r], cum[m][0]);
            narrow(n + 1 - ch, n - ch, n + 1);
        endfunction

        function void adapt_model(int m, int unsigned ch);
            int unsigned n, i, rk, ns, acc, s, a, b;
            n = asz[m];
            ns = used[m];
            if (ns >= NSLOT) ns = NSLOT - 1;
            if (cum[m][0] >= FREQ_LIM) begin
                acc = 0;
                for (i = ns; i > 0; i--) begin
                    freq[m][i] >>= 1;
                    if (freq[m][i] == 0) begin
                        s = r2s[m][i];
                        if (s <= 256) s2r[m][s] = 0;
                        if (ns > 0) ns--;
                    end
                    cum[m][i] = acc;
                    acc += freq[m][i];
                end
                cum[m][0] = acc;
                if (ns + 1 < NSLOT) ns++;
                s2r[m][n] = ns;
                r2s[m][ns] = n;
                freq[m][ns] = 1;
                i = ns;
                while (i > 0) begin
                    i--;
                    cum[m][i]++;
                end
            end
            rk = clip_rank(s2r[m][ch]);
            if (rk == 0) begin
                if (ns + 1 >= NSLOT) begin
                    used[m] = ns;
                    return;
                end
                ns++;
                s2r[m][ch] = ns;
                r2s[m][ns] = ch;
                i = ns;
            end else begin
                i = rk;
                while (i > 0 && freq[m][i] == freq[m][i-1]) i--;
                if (i < rk) begin
                    a = r2s[m][i];
                    b = r2s[m][rk];
                    r2s[m][i] = b;
                    r2s[m][rk] = a;
                    if (a <= 256) s2r[m][a] = rk;
                    if (b <= 256) s2r[m][b] = i;
                end
            end
            freq[m][i]++;
            while (i > 0) begin
                i--;
                cum[m][i]++;
            end
            used[m] = ns;
        endfunction

        // Called for every input beat taken by the block.
        function void note_input(aae_pkg::in_item_t it);
            int m;
            n_emit = 0;
            m = int'(it.model_sel);
            if (it.kind == KIND_RESERVED || m >= aae_pkg::MODELS) return;
            if (it.kind == aae_pkg::KIND_FINISH) begin
                bump_follow();
                emit_bit(lo_q < QTR_C ? 1'b0 : 1'b1);
            end else begin
                if (it.sym_in >= asz[m]) return;
                if (it.kind == aae_pkg::KIND_ENCODE) encode_sym(m, int'(it.sym_in));
                else adapt_model(m, int'(it.sym_in));
            end
            if (n_emit > 0) pending_beats[$].last_out = 1'b1;
        endfunction

        function void check_result(aae_pkg::out_item_t got);
            aae_pkg::out_item_t want;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending_beats.pop_front();
            if (got.lead_bit !== want.lead_bit || got.follow_run !== want.follow_run ||
                got.last_out !== want.last_out) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected bit %0d run %0d last %0d, got %0d %0d %0d",
                             want.lead_bit, want.follow_run, want.last_out,
                             got.lead_bit, got.follow_run, got.last_out);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    aae_pkg::in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    aae_pkg::out_item_t m_data;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_wdata;

    encoder_scoreboard sb;
    bit quiet;
    bit hold_req;
    int hold_cnt;

    adaptive_arithmetic_encoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("[adaptive_arithmetic_encoder_top] ERROR");
        $finish;
    end

    // Result side: checks every beat and applies random or long back-pressure.
    initial begin
        m_ready = 1'b0;
        hold_cnt = 0;
        forever @(posedge aclk) begin
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 3000;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic send_beat(aae_pkg::in_item_t it);
        if (!quiet && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic send_fields(logic [1:0] k, logic [1:0] m, logic [7:0] s);
        aae_pkg::in_item_t it;
        it.kind = k;
        it.model_sel = m;
        it.sym_in = s;
        send_beat(it);
    endtask

    // Lets all expected beats arrive, then allows for a trailing update.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [8:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_size(int'(idx), val);
    endtask

    task automatic random_beats(int count);
        aae_pkg::in_item_t it;
        int m, p;
        for (int j = 0; j < count; j++) begin
            m = $urandom_range(aae_pkg::MODELS - 1);
            p = $urandom_range(99);
            it.model_sel = 2'(m);
            // Repeated small symbols make the models adapt and reorder.
            if ($urandom_range(99) < 60)
                it.sym_in = 8'($urandom_range(sb.asz[m] < 6 ? sb.asz[m] - 1 : 5));
            else
                it.sym_in = 8'($urandom_range(sb.asz[m] - 1));
            if (p < 45) it.kind = aae_pkg::KIND_ENCODE;
            else if (p < 85) it.kind = aae_pkg::KIND_UPDATE;
            else if (p < 90) it.kind = aae_pkg::KIND_FINISH;
            else if (p < 95) it.kind = KIND_RESERVED;
            else begin
                it.kind = 2'($urandom_range(1));
                it.sym_in = 8'($urandom_range(255));
            end
            send_beat(it);
        end
    endtask

    initial begin
        sb = new();
        sb.errors = 0;
        sb.reset_all();
        quiet = 1'b0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: escape path, seen symbols, extreme symbols, finish, ignored kind.
        send_fields(aae_pkg::KIND_ENCODE, 2'd0, 8'd0);
        send_fields(aae_pkg::KIND_UPDATE, 2'd0, 8'd0);
        send_fields(aae_pkg::KIND_ENCODE, 2'd0, 8'd0);
        send_fields(aae_pkg::KIND_ENCODE, 2'd3, 8'd255);
        send_fields(aae_pkg::KIND_UPDATE, 2'd3, 8'd255);
        send_fields(aae_pkg::KIND_UPDATE, 2'd3, 8'd255);
        send_fields(aae_pkg::KIND_ENCODE, 2'd3, 8'd255);
        send_fields(KIND_RESERVED, 2'd1, 8'd7);
        send_fields(aae_pkg::KIND_FINISH, 2'd2, 8'd0);
        send_fields(aae_pkg::KIND_UPDATE, 2'd1, 8'd3);
        send_fields(aae_pkg::KIND_UPDATE, 2'd1, 8'd4);
        send_fields(aae_pkg::KIND_UPDATE, 2'd1, 8'd4);
        send_fields(aae_pkg::KIND_ENCODE, 2'd1, 8'd3);
        send_fields(aae_pkg::KIND_FINISH, 2'd1, 8'd0);

        // Extreme sizes: zero is taken as one, oversize as the maximum.
        write_size(2'd0, 9'd0);
        write_size(2'd1, 9'd1);
        write_size(2'd2, 9'd256);
        write_size(2'd3, 9'd511);
        send_fields(aae_pkg::KIND_ENCODE, 2'd0, 8'd0);
        send_fields(aae_pkg::KIND_ENCODE, 2'd0, 8'd1);
        send_fields(aae_pkg::KIND_UPDATE, 2'd1, 8'd0);
        send_fields(aae_pkg::KIND_ENCODE, 2'd1, 8'd0);
        send_fields(aae_pkg::KIND_ENCODE, 2'd3, 8'd255);
        send_fields(aae_pkg::KIND_FINISH, 2'd3, 8'd0);

        write_size(2'd0, 9'd2);
        write_size(2'd1, 9'd255);
        write_size(2'd2, 9'($urandom_range(3, 255)));
        write_size(2'd3, 9'd16);

        random_beats(30);
        quiet = 1'b1;
        random_beats(25);
        quiet = 1'b0;
        // Long stall on the result side while the sender keeps offering.
        hold_req = 1'b1;
        random_beats(30);
        random_beats(30);

        // A short run on a two-symbol model.
        write_size(2'd0, 9'd2);
        for (int j = 0; j < 8; j++) begin
            send_fields(aae_pkg::KIND_ENCODE, 2'd0, 8'($urandom_range(1)));
            send_fields(aae_pkg::KIND_UPDATE, 2'd0, 8'($urandom_range(1)));
        end
        send_fields(aae_pkg::KIND_FINISH, 2'd0, 8'd0);

        settle();
        if (sb.pending_beats.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("[adaptive_arithmetic_encoder_top] OK");
        end else begin
            $display("[adaptive_arithmetic_encoder_top] ERROR");
        end
        $finish;
    end

endmodule
